// ----- sv/plt_pkg.sv -----
// Shared types and constants for the piecewise-linear two-value lookup unit.
package plt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int DIST_W          = 16;
    localparam int VAL_W           = 16;
    localparam int COUNT_W         = 6;
    localparam int SLOT_W          = 5;
    localparam int WIDE_W          = 9;
    localparam int NUM_W           = 35;
    localparam int DIV_STEPS       = 16;
    localparam int DIV_CNT_W       = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        [DIST_W-1:0] distance;
        logic signed [VAL_W-1:0]  value_a;
        logic signed [VAL_W-1:0]  value_b;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_GO,
        ST_DIV_WAIT
    } t_state;

endpackage

// ----- sv/plt_mem.sv -----
// Breakpoint storage: one write port, one registered read port.
module plt_mem #(
    parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  plt_pkg::t_entry                i_wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output plt_pkg::t_entry                o_rd_data
);
    import plt_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/plt_div.sv -----
// Restoring serial divider, one quotient bit per cycle, truncates toward zero.
module plt_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [plt_pkg::NUM_W-1:0]    i_num,
    input  logic        [plt_pkg::DIST_W-1:0]   i_den,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [plt_pkg::VAL_W-1:0]    o_quot
);
    import plt_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIST_W-1:0]    r_rem;
    logic [VAL_W-1:0]     r_dvd;
    logic [DIST_W-1:0]    r_den;
    logic                 r_neg;

    logic [NUM_W-1:0]     mag;
    logic [DIST_W:0]      trial;
    logic [DIST_W:0]      diff;
    logic                 ge;

    assign mag   = i_num[NUM_W-1] ? (~i_num + NUM_W'(1)) : i_num;
    assign trial = {r_rem, r_dvd[VAL_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= mag[DIST_W+VAL_W-1:VAL_W];
            r_dvd <= mag[VAL_W-1:0];
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
            r_dvd <= {r_dvd[VAL_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_dvd + VAL_W'(1)) : r_dvd;

endmodule

// ----- sv/piecewise_linear_two_value_lut_unit.sv -----
// Top level: breakpoint table, scan sequencer, shared multiplier and divider.
// Load item: busy stays low, no result.
// Query item: a scan of k entries (k = 1 to entry count, one table read per cycle),
//   then per value two multiply steps and a 16-step divider.
// A clamped query finishes after the scan. Result strobes o_valid for one cycle.
// Synchronous active-low reset clears control and sets the entry count to one;
//   table contents are undefined until loaded.
module piecewise_linear_two_value_lut_unit #(
    parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_opcode,
    input  logic        [plt_pkg::SLOT_W-1:0]    i_entry_index,
    input  logic        [plt_pkg::DIST_W-1:0]    i_entry_distance,
    input  logic signed [plt_pkg::VAL_W-1:0]     i_entry_value_a,
    input  logic signed [plt_pkg::VAL_W-1:0]     i_entry_value_b,
    input  logic        [plt_pkg::DIST_W-1:0]    i_query_distance,
    input  logic                                 i_cfg_wr_en,
    input  logic        [plt_pkg::COUNT_W-1:0]   i_cfg_wr_data,
    output logic                                 o_valid,
    output logic signed [plt_pkg::VAL_W-1:0]     o_value_a,
    output logic signed [plt_pkg::VAL_W-1:0]     o_value_b,
    output logic                                 o_below_range,
    output logic                                 o_above_range
);
    import plt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(TABLE_DEPTH);

    t_state                   r_state, n_state;
    logic [COUNT_W-1:0]       r_entry_count;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [DIST_W-1:0]        r_q, n_q;
    t_entry                   r_prev, n_prev;
    t_entry                   r_cur, n_cur;
    logic [DIST_W-1:0]        r_span, n_span;
    logic [DIST_W-1:0]        r_t, n_t;
    logic signed [NUM_W-1:0]  r_acc, n_acc;
    logic                     r_chan_b, n_chan_b;
    logic signed [VAL_W-1:0]  r_res_a, n_res_a;
    logic                     r_valid, n_valid;
    logic signed [VAL_W-1:0]  r_value_a, n_value_a;
    logic signed [VAL_W-1:0]  r_value_b, n_value_b;
    logic                     r_below, n_below;
    logic                     r_above, n_above;

    logic [WIDE_W-1:0]        cnt_wide;
    logic [WIDE_W-1:0]        live_wide;
    logic [WIDE_W-1:0]        last_wide;
    logic [IDX_W-1:0]         last_idx;
    logic [WIDE_W-1:0]        wr_wide;
    logic                     wr_en;
    t_entry                   wr_data;
    t_entry                   rd_data;

    logic signed [VAL_W-1:0]   v1, v2;
    logic signed [VAL_W:0]     delta;
    logic signed [VAL_W:0]     op_x, op_y;
    logic signed [2*VAL_W+1:0] product;

    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic signed [VAL_W-1:0]  div_quot;

    assign busy = (r_state != ST_IDLE);

    assign cnt_wide  = WIDE_W'(r_entry_count);
    assign live_wide = (cnt_wide == '0) ? WIDE_W'(1) :
                       (cnt_wide > DEPTH_WIDE) ? DEPTH_WIDE : cnt_wide;
    assign last_wide = live_wide - WIDE_W'(1);
    assign last_idx  = last_wide[IDX_W-1:0];

    assign wr_wide = WIDE_W'(i_entry_index);
    assign wr_en   = start && !busy && (i_opcode == OP_LOAD) && (wr_wide < DEPTH_WIDE);
    assign wr_data = '{distance: i_entry_distance, value_a: i_entry_value_a,
                       value_b: i_entry_value_b};

    plt_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_wide[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    assign v1      = r_chan_b ? r_prev.value_b : r_prev.value_a;
    assign v2      = r_chan_b ? r_cur.value_b : r_cur.value_a;
    assign delta   = {v2[VAL_W-1], v2} - {v1[VAL_W-1], v1};
    assign op_x    = (r_state == ST_MUL_LO) ? {v1[VAL_W-1], v1} : delta;
    assign op_y    = (r_state == ST_MUL_LO) ? $signed({1'b0, r_span}) : $signed({1'b0, r_t});
    assign product = op_x * op_y;

    plt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_span),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_q       = r_q;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_span    = r_span;
        n_t       = r_t;
        n_acc     = r_acc;
        n_chan_b  = r_chan_b;
        n_res_a   = r_res_a;
        n_valid   = 1'b0;
        n_value_a = r_value_a;
        n_value_b = r_value_b;
        n_below   = r_below;
        n_above   = r_above;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (start && (i_opcode == OP_QUERY)) begin
                    n_q     = i_query_distance;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_data.distance >= r_q) begin
                    if (r_idx == '0) begin
                        n_value_a = rd_data.value_a;
                        n_value_b = rd_data.value_b;
                        n_below   = (r_q < rd_data.distance);
                        n_above   = 1'b0;
                        n_valid   = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_cur    = rd_data;
                        n_span   = rd_data.distance - r_prev.distance;
                        n_t      = r_q - r_prev.distance;
                        n_chan_b = 1'b0;
                        n_state  = ST_MUL_LO;
                    end
                end else if (r_idx == last_idx) begin
                    n_value_a = rd_data.value_a;
                    n_value_b = rd_data.value_b;
                    n_below   = 1'b0;
                    n_above   = 1'b1;
                    n_valid   = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    n_prev = rd_data;
                    n_idx  = r_idx + IDX_W'(1);
                end
            end
            ST_MUL_LO: begin
                n_acc   = NUM_W'(product);
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                n_acc   = r_acc + NUM_W'(product);
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (!r_chan_b) begin
                        n_res_a  = div_quot;
                        n_chan_b = 1'b1;
                        n_state  = ST_MUL_LO;
                    end else begin
                        n_value_a = r_res_a;
                        n_value_b = div_quot;
                        n_below   = 1'b0;
                        n_above   = 1'b0;
                        n_valid   = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= COUNT_W'(1);
            r_valid       <= 1'b0;
            r_idx         <= '0;
            r_chan_b      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_idx    <= n_idx;
            r_chan_b <= n_chan_b;
            if (i_cfg_wr_en) begin
                r_entry_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_prev    <= n_prev;
        r_cur     <= n_cur;
        r_span    <= n_span;
        r_t       <= n_t;
        r_acc     <= n_acc;
        r_res_a   <= n_res_a;
        r_value_a <= n_value_a;
        r_value_b <= n_value_b;
        r_below   <= n_below;
        r_above   <= n_above;
    end

    assign o_valid       = r_valid;
    assign o_value_a     = r_value_a;
    assign o_value_b     = r_value_b;
    assign o_below_range = r_below;
    assign o_above_range = r_above;

    a_valid_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == ST_SCAN || $past(r_state) == ST_DIV_WAIT))
        else $error("result strobe without a finished query");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_below && r_above))
        else $error("both clamp flags raised");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_GO) |-> !div_busy)
        else $error("divider started while busy");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= last_idx))
        else $error("scan index past last entry");

endmodule
